@@ src/ptm_pkg.sv @@
// ----------------------------------------------------------------------------
// ptm_pkg: shared constants for the page table mapper
// Table pool geometry, derived address widths, status and register codes.
// ----------------------------------------------------------------------------
`default_nettype none

package ptm_pkg;

   // pool geometry
   localparam int TABLE_SLOTS       = 16;
   localparam int ENTRIES_PER_TABLE = 512;
   localparam int TABLE_DEPTH       = TABLE_SLOTS * ENTRIES_PER_TABLE;

   // derived widths
   localparam int IDX_W   = $clog2(ENTRIES_PER_TABLE);
   localparam int SLOT_W  = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
   localparam int ADDR_W  = $clog2(TABLE_DEPTH);
   localparam int USED_W  = $clog2(TABLE_SLOTS + 1);

   // field widths
   localparam int ADDR48_W = 48;
   localparam int ENTRY_W  = 64;

   // result status codes
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_BAD_ORDER = 2'd1;
   localparam logic [1:0] STATUS_POOL_FULL = 2'd2;
   localparam logic [1:0] STATUS_BAD_PTR   = 2'd3;

   // configuration register indexes
   localparam logic CSR_ROOT_DEPTH = 1'b0;
   localparam logic CSR_POOL_BASE  = 1'b1;

endpackage

`default_nettype wire

@@ src/ptm_ram.sv @@
// ----------------------------------------------------------------------------
// ptm_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module ptm_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 8192
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ src/page_table_mapper_unit.sv @@
// ----------------------------------------------------------------------------
// page_table_mapper_unit: four-level translation table builder
// Maps runs of pages into a pool of 512-entry tables, allocating tables on
// the walk and writing one leaf entry per page, one result beat per page.
// ----------------------------------------------------------------------------
// Per page: ST_PAGE, then a read and an evaluate state for each of the L levels
// walked above the leaf (L = 0..3), then ST_LEAF, all on the table RAM.
// The first result beat is registered out of ST_LEAF; a bad order answers in
// the cycle after start. busy stays high until the last beat is shown; no
// back-pressure. After reset all 8192 table RAM entries are cleared with busy
// high; configuration writes are taken only while idle with start low.
`default_nettype none

module page_table_mapper_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   // request
   input  wire logic        start,
   output logic             busy,
   input  wire logic [47:0] req_virt_base,
   input  wire logic [47:0] req_phys_base,
   input  wire logic [5:0]  req_page_order,
   input  wire logic [6:0]  req_page_count,
   input  wire logic [63:0] req_attributes,
   // result
   output logic             rsp_valid,
   output logic [1:0]       rsp_status,
   output logic [1:0]       rsp_entry_level,
   output logic [3:0]       rsp_entry_slot,
   output logic [8:0]       rsp_entry_index,
   output logic [63:0]      rsp_entry_value,
   output logic [1:0]       rsp_tables_added,
   output logic             rsp_last_page,
   // configuration
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_index,
   input  wire logic [47:0] csr_data
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_PAGE,
      ST_READ,
      ST_EVAL,
      ST_LEAF
   } state_type;

   localparam int ADDR_W = ptm_pkg::ADDR_W;
   localparam int SLOT_W = ptm_pkg::SLOT_W;
   localparam int IDX_W  = ptm_pkg::IDX_W;
   localparam int USED_W = ptm_pkg::USED_W;
   localparam logic [ADDR_W-1:0] CLEAR_LAST = ADDR_W'(ptm_pkg::TABLE_DEPTH - 1);
   localparam logic [USED_W-1:0] SLOTS_U    = USED_W'(ptm_pkg::TABLE_SLOTS);
   localparam logic [51:0]       SLOTS_PAGE = 52'(ptm_pkg::TABLE_SLOTS);

   // address shift of each level
   function automatic logic [5:0] level_shift(input logic [1:0] lvl);
      logic [5:0] sh;
      case (lvl)
         2'd0:    sh = 6'd39;
         2'd1:    sh = 6'd30;
         2'd2:    sh = 6'd21;
         default: sh = 6'd12;
      endcase
      return sh;
   endfunction

   // table index of an address at a level
   function automatic logic [IDX_W-1:0] index_of(input logic [47:0] va,
                                                 input logic [1:0]  lvl);
      logic [47:0] shifted;
      shifted = va >> level_shift(lvl);
      return shifted[IDX_W-1:0];
   endfunction

   // state and registered outputs
   state_type           state_ff, state_in;
   logic [ADDR_W-1:0]   clr_cnt_ff, clr_cnt_in;
   logic [2:0]          root_depth_ff, root_depth_in;
   logic [47:0]         pool_base_ff, pool_base_in;
   logic [USED_W-1:0]   used_ff, used_in;
   logic [47:0]         va_ff, va_in;
   logic [48:0]         pa_ff, pa_in;
   logic [63:0]         attr_ff, attr_in;
   logic [6:0]          pages_left_ff, pages_left_in;
   logic [1:0]          start_lvl_ff, start_lvl_in;
   logic [1:0]          target_ff, target_in;
   logic [1:0]          level_ff, level_in;
   logic [SLOT_W-1:0]   slot_ff, slot_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic [1:0]          added_ff, added_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [1:0]          rsp_status_ff, rsp_status_in;
   logic [1:0]          rsp_level_ff, rsp_level_in;
   logic [3:0]          rsp_slot_ff, rsp_slot_in;
   logic [IDX_W-1:0]    rsp_index_ff, rsp_index_in;
   logic [63:0]         rsp_value_ff, rsp_value_in;
   logic [1:0]          rsp_added_ff, rsp_added_in;
   logic                rsp_last_ff, rsp_last_in;

   // table RAM port
   logic                ram_wr_en;
   logic [ADDR_W-1:0]   ram_wr_addr;
   logic [63:0]         ram_wr_data;
   logic [ADDR_W-1:0]   ram_rd_addr;
   logic [63:0]         ram_rd_data;

   // request decode
   logic [2:0]          depth_c;
   logic [2:0]          start_c;
   logic                found_c;
   logic [1:0]          target_c;
   logic [6:0]          count_c;

   // walk datapath
   logic [36:0]         alloc_sum;
   logic [63:0]         alloc_ptr;
   logic [52:0]         ptr_diff;
   logic                ptr_ok;
   logic                pool_full;
   logic [1:0]          next_lvl;
   logic [48:0]         page_step;
   logic [ADDR_W-1:0]   walk_addr;

   assign busy      = (state_ff != ST_IDLE) || rsp_valid_ff;
   // registers only change while no request is in flight or entering
   assign csr_ready = !busy && !start;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_entry_level  = rsp_level_ff;
   assign rsp_entry_slot   = rsp_slot_ff;
   assign rsp_entry_index  = rsp_index_ff;
   assign rsp_entry_value  = rsp_value_ff;
   assign rsp_tables_added = rsp_added_ff;
   assign rsp_last_page    = rsp_last_ff;

   assign walk_addr   = {slot_ff, idx_ff};
   assign ram_rd_addr = walk_addr;

   // start level and leaf level search
   always_comb begin
      depth_c  = (root_depth_ff > 3'd4) ? 3'd4 : root_depth_ff;
      start_c  = 3'd4 - depth_c;
      found_c  = 1'b0;
      target_c = 2'd0;
      for (int j = 0; j < 4; j++) begin
         if (!found_c && (3'(j) >= start_c) &&
             (level_shift(2'(j)) == req_page_order)) begin
            found_c  = 1'b1;
            target_c = 2'(j);
         end
      end
      count_c = (req_page_count > 7'd64) ? 7'd64 : req_page_count;
   end

   // pointer allocation and decode
   always_comb begin
      alloc_sum = {1'b0, pool_base_ff[47:12]} + 37'(used_ff);
      alloc_ptr = {15'b0, alloc_sum, 12'h003};
      ptr_diff  = {1'b0, ram_rd_data[63:12]} - {17'b0, pool_base_ff[47:12]};
      ptr_ok    = !ptr_diff[52] && (ram_rd_data[11:2] == 10'd0) &&
                  (ptr_diff[51:0] < SLOTS_PAGE);
      pool_full = (used_ff >= SLOTS_U);
      next_lvl  = level_ff + 2'd1;
      page_step = 49'(1) << level_shift(target_ff);
   end

   // sequencer next state
   always_comb begin
      state_in      = state_ff;
      clr_cnt_in    = clr_cnt_ff;
      root_depth_in = root_depth_ff;
      pool_base_in  = pool_base_ff;
      used_in       = used_ff;
      va_in         = va_ff;
      pa_in         = pa_ff;
      attr_in       = attr_ff;
      pages_left_in = pages_left_ff;
      start_lvl_in  = start_lvl_ff;
      target_in     = target_ff;
      level_in      = level_ff;
      slot_in       = slot_ff;
      idx_in        = idx_ff;
      added_in      = added_ff;

      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_level_in  = rsp_level_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_added_in  = rsp_added_ff;
      rsp_last_in   = rsp_last_ff;

      ram_wr_en   = 1'b0;
      ram_wr_addr = walk_addr;
      ram_wr_data = 64'd0;

      // configuration writes
      if (csr_valid && csr_ready) begin
         case (csr_index)
            ptm_pkg::CSR_ROOT_DEPTH: root_depth_in = csr_data[2:0];
            ptm_pkg::CSR_POOL_BASE:  pool_base_in  = csr_data;
            default:                 root_depth_in = root_depth_ff;
         endcase
      end

      case (state_ff)
         // zero the table RAM one entry per cycle
         ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_cnt_ff;
            clr_cnt_in  = clr_cnt_ff + ADDR_W'(1);
            if (clr_cnt_ff == CLEAR_LAST) begin
               state_in = ST_IDLE;
            end
         end

         // take a request
         ST_IDLE: begin
            if (start && !busy) begin
               va_in         = req_virt_base;
               pa_in         = {1'b0, req_phys_base};
               attr_in       = req_attributes;
               pages_left_in = count_c;
               start_lvl_in  = start_c[1:0];
               target_in     = target_c;
               if (count_c == 7'd0) begin
                  state_in = ST_IDLE;
               end else if (!found_c) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ptm_pkg::STATUS_BAD_ORDER;
                  rsp_level_in  = 2'd0;
                  rsp_slot_in   = 4'd0;
                  rsp_index_in  = '0;
                  rsp_value_in  = 64'd0;
                  rsp_added_in  = 2'd0;
                  rsp_last_in   = 1'b1;
               end else begin
                  state_in = ST_PAGE;
               end
            end
         end

         // begin the walk for one page at the root
         ST_PAGE: begin
            slot_in  = '0;
            level_in = start_lvl_ff;
            idx_in   = index_of(va_ff, start_lvl_ff);
            added_in = 2'd0;
            state_in = (start_lvl_ff == target_ff) ? ST_LEAF : ST_READ;
         end

         // entry read issued; data lands next cycle
         ST_READ: begin
            state_in = ST_EVAL;
         end

         // allocate or follow the table pointer, or end the request with an error
         ST_EVAL: begin
            if (ram_rd_data == 64'd0 && pool_full) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ptm_pkg::STATUS_POOL_FULL;
               rsp_level_in  = 2'd0;
               rsp_slot_in   = 4'd0;
               rsp_index_in  = '0;
               rsp_value_in  = 64'd0;
               rsp_added_in  = added_ff;
               rsp_last_in   = 1'b1;
               state_in      = ST_IDLE;
            end else if (ram_rd_data == 64'd0 || ptr_ok) begin
               if (ram_rd_data == 64'd0) begin
                  ram_wr_en   = 1'b1;
                  ram_wr_data = alloc_ptr;
                  used_in     = used_ff + USED_W'(1);
                  added_in    = added_ff + 2'd1;
                  slot_in     = used_ff[SLOT_W-1:0];
               end else begin
                  slot_in = ptr_diff[SLOT_W-1:0];
               end
               level_in = next_lvl;
               idx_in   = index_of(va_ff, next_lvl);
               state_in = (next_lvl == target_ff) ? ST_LEAF : ST_READ;
            end else begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ptm_pkg::STATUS_BAD_PTR;
               rsp_level_in  = 2'd0;
               rsp_slot_in   = 4'd0;
               rsp_index_in  = '0;
               rsp_value_in  = 64'd0;
               rsp_added_in  = added_ff;
               rsp_last_in   = 1'b1;
               state_in      = ST_IDLE;
            end
         end

         // write the leaf and report the page
         ST_LEAF: begin
            ram_wr_en     = 1'b1;
            ram_wr_data   = {15'b0, pa_ff} | attr_ff;
            rsp_valid_in  = 1'b1;
            rsp_status_in = ptm_pkg::STATUS_OK;
            rsp_level_in  = target_ff;
            rsp_slot_in   = 4'(slot_ff);
            rsp_index_in  = idx_ff;
            rsp_value_in  = {15'b0, pa_ff} | attr_ff;
            rsp_added_in  = added_ff;
            rsp_last_in   = (pages_left_ff == 7'd1);
            pages_left_in = pages_left_ff - 7'd1;
            va_in         = va_ff + page_step[47:0];
            pa_in         = pa_ff + page_step;
            state_in      = (pages_left_ff == 7'd1) ? ST_IDLE : ST_PAGE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_cnt_ff    <= '0;
         root_depth_ff <= 3'd4;
         pool_base_ff  <= 48'd0;
         used_ff       <= USED_W'(1);
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_cnt_ff    <= clr_cnt_in;
         root_depth_ff <= root_depth_in;
         pool_base_ff  <= pool_base_in;
         used_ff       <= used_in;
         rsp_valid_ff  <= rsp_valid_in;
         va_ff         <= va_in;
         pa_ff         <= pa_in;
         attr_ff       <= attr_in;
         pages_left_ff <= pages_left_in;
         start_lvl_ff  <= start_lvl_in;
         target_ff     <= target_in;
         level_ff      <= level_in;
         slot_ff       <= slot_in;
         idx_ff        <= idx_in;
         added_ff      <= added_in;
         rsp_status_ff <= rsp_status_in;
         rsp_level_ff  <= rsp_level_in;
         rsp_slot_ff   <= rsp_slot_in;
         rsp_index_ff  <= rsp_index_in;
         rsp_value_ff  <= rsp_value_in;
         rsp_added_ff  <= rsp_added_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   // table store
   ptm_ram #(
      .WIDTH (64),
      .DEPTH (ptm_pkg::TABLE_DEPTH)
   ) u_table_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

endmodule

`default_nettype wire

@@ src/ptm_checker.sv @@
// ----------------------------------------------------------------------------
// ptm_checker: port-level checks for page_table_mapper_unit
// Watches the result and busy ports over time.
// ----------------------------------------------------------------------------
`default_nettype none

module ptm_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        busy,
   input wire logic        rsp_valid,
   input wire logic [1:0]  rsp_status,
   input wire logic [1:0]  rsp_entry_level,
   input wire logic [63:0] rsp_entry_value,
   input wire logic [1:0]  rsp_tables_added,
   input wire logic        rsp_last_page
);

   // table clearing keeps the block busy right after reset
   a_busy_after_reset: assert property (@(posedge clock)
      $fell(reset) |-> busy)
      else $error("busy low right after reset");

   // a result beat is only shown while the block is busy
   a_beat_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result beat while not busy");

   // beats never come in two adjacent cycles
   a_beat_spacing: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result beats back to back");

   // any error ends the request
   a_error_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ptm_pkg::STATUS_OK) |-> rsp_last_page)
      else $error("error beat not marked last");

   // a bad order reports nothing written
   a_bad_order_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ptm_pkg::STATUS_BAD_ORDER) |->
      (rsp_entry_value == 64'd0 && rsp_tables_added == 2'd0 &&
       rsp_entry_level == 2'd0))
      else $error("bad order beat carries data");

endmodule

bind page_table_mapper_unit ptm_checker u_ptm_checker (
   .clock            (clock),
   .reset            (reset),
   .busy             (busy),
   .rsp_valid        (rsp_valid),
   .rsp_status       (rsp_status),
   .rsp_entry_level  (rsp_entry_level),
   .rsp_entry_value  (rsp_entry_value),
   .rsp_tables_added (rsp_tables_added),
   .rsp_last_page    (rsp_last_page)
);

`default_nettype wire

@@ verif/page_table_mapper_unit_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_table_mapper_unit_test: self-checking bench for the table mapper
// Drives map requests through the start/busy port, keeps its own copy of the
// table pool and walk state, and compares every result beat field by field
// against the predicted leaf writes, allocations and error codes.
// ----------------------------------------------------------------------------

module page_table_mapper_unit_test;

   // pool base used by most phases, 1 GiB
   localparam logic [47:0] POOL_A      = 48'h0000_4000_0000;
   // two address regions sharing tables: root entries 0 and 1
   localparam logic [47:0] REGION_LO   = 48'h0000_0000_0000;
   localparam logic [47:0] REGION_HI   = 48'h0080_0000_0000;
   // clearing after reset is a long quiet stretch; any other quiet stretch is short
   localparam int          QUIET_LIMIT = 30000;

   localparam int unsigned LEVEL_SHIFT [0:3] = '{39, 30, 21, 12};

   typedef struct packed {
      logic [1:0]  status;
      logic [1:0]  level;
      logic [3:0]  slot;
      logic [8:0]  idx;
      logic [63:0] value;
      logic [1:0]  added;
      logic        last_page;
   } entry_beat_type;

   // -------------------------------------------------------------------------
   // Scoreboard: shadow page table pool and queue of predicted entry beats
   // -------------------------------------------------------------------------
   class mapping_scoreboard_type;
      bit [63:0]      table_copy [ptm_pkg::TABLE_DEPTH];
      int unsigned    slots_used = 1;
      bit [2:0]       depth_reg  = 3'd4;
      bit [47:0]      pool_reg   = '0;
      entry_beat_type pending_entries [$];
      int unsigned    error_count = 0;

      function void set_register(logic index, logic [47:0] data);
         if (index == ptm_pkg::CSR_ROOT_DEPTH)
            depth_reg = data[2:0];
         else
            pool_reg = data;
      endfunction

      function bit [63:0] pool_origin();
         return {16'd0, pool_reg} & ~64'hfff;
      endfunction

      // table pointer -> slot; fails outside the pool or off a table boundary
      function bit decode_slot(bit [63:0] entry, output int unsigned slot);
         bit [63:0] ptr;
         bit [63:0] offset;
         ptr = entry & ~64'd3;
         if (ptr < pool_origin())
            return 1'b0;
         offset = ptr - pool_origin();
         if (offset[11:0] != 12'd0 || (offset >> 12) >= ptm_pkg::TABLE_SLOTS)
            return 1'b0;
         slot = int'(offset >> 12);
         return 1'b1;
      endfunction

      // walk and fill the shadow tables for one accepted request
      function void note_request(logic [47:0] virt, logic [47:0] phys,
                                 logic [5:0] order, logic [6:0] count,
                                 logic [63:0] attr);
         int unsigned depth, first_lvl, leaf_lvl, pages;
         int unsigned slot, next_slot, idx, added, pos;
         bit [63:0]   step, va, value;
         logic [1:0]  st;
         depth     = (depth_reg > 3'd4) ? 4 : depth_reg;
         first_lvl = 4 - depth;
         leaf_lvl  = 4;
         pages     = (count > 7'd64) ? 64 : count;
         if (pages == 0)
            return;
         for (int j = first_lvl; j < 4; j++)
            if (leaf_lvl == 4 && LEVEL_SHIFT[j] == order)
               leaf_lvl = j;
         if (leaf_lvl == 4) begin
            pending_entries.push_back('{ptm_pkg::STATUS_BAD_ORDER, 2'd0, 4'd0, 9'd0,
                                        64'd0, 2'd0, 1'b1});
            return;
         end
         for (int i = 0; i < pages; i++) begin
            step  = 64'(i) << order;
            va    = {16'd0, virt} + step;
            value = ({16'd0, phys} + step) | attr;
            slot  = 0;
            added = 0;
            st    = ptm_pkg::STATUS_OK;
            idx   = int'((va >> LEVEL_SHIFT[first_lvl]) & 64'h1ff);
            for (int j = first_lvl; j < leaf_lvl && st == ptm_pkg::STATUS_OK; j++) begin
               pos = slot * ptm_pkg::ENTRIES_PER_TABLE + idx;
               // empty entry: hang a fresh table from the pool
               if (table_copy[pos] == 64'd0) begin
                  if (slots_used >= ptm_pkg::TABLE_SLOTS)
                     st = ptm_pkg::STATUS_POOL_FULL;
                  else begin
                     table_copy[pos] = (pool_origin() + 64'(slots_used) * 64'd4096)
                                       | 64'd3;
                     slots_used++;
                     added++;
                  end
               end
               if (st == ptm_pkg::STATUS_OK) begin
                  if (decode_slot(table_copy[pos], next_slot)) begin
                     slot = next_slot;
                     idx  = int'((va >> LEVEL_SHIFT[j + 1]) & 64'h1ff);
                  end else
                     st = ptm_pkg::STATUS_BAD_PTR;
               end
            end
            // a failed walk ends the request
            if (st != ptm_pkg::STATUS_OK) begin
               pending_entries.push_back('{st, 2'd0, 4'd0, 9'd0, 64'd0,
                                           2'(added), 1'b1});
               return;
            end
            table_copy[slot * ptm_pkg::ENTRIES_PER_TABLE + idx] = value;
            pending_entries.push_back('{ptm_pkg::STATUS_OK, 2'(leaf_lvl), 4'(slot),
                                        9'(idx), value, 2'(added), i == pages - 1});
         end
      endfunction

      function void check_field(string name, logic [63:0] want, logic [63:0] got);
         if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            error_count++;
         end
      endfunction

      function void check_entry(entry_beat_type got);
         entry_beat_type want;
         if (pending_entries.size() == 0) begin
            $error("result beat with nothing expected: status %0d value 0x%0h",
                   got.status, got.value);
            error_count++;
            return;
         end
         want = pending_entries.pop_front();
         check_field("status", want.status, got.status);
         check_field("entry_level", want.level, got.level);
         check_field("entry_slot", want.slot, got.slot);
         check_field("entry_index", want.idx, got.idx);
         check_field("entry_value", want.value, got.value);
         check_field("tables_added", want.added, got.added);
         check_field("last_page", want.last_page, got.last_page);
      endfunction

      function int unsigned pending();
         return pending_entries.size();
      endfunction

      function int unsigned close_out();
         if (pending_entries.size() != 0) begin
            $error("%0d result beats never arrived", pending_entries.size());
            error_count++;
         end
         return error_count;
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // DUT signals
   // -------------------------------------------------------------------------
   logic        clock          = 1'b0;
   logic        reset          = 1'b1;
   logic        start          = 1'b0;
   logic        busy;
   logic [47:0] req_virt_base  = '0;
   logic [47:0] req_phys_base  = '0;
   logic [5:0]  req_page_order = '0;
   logic [6:0]  req_page_count = '0;
   logic [63:0] req_attributes = '0;
   logic        rsp_valid;
   logic [1:0]  rsp_status;
   logic [1:0]  rsp_entry_level;
   logic [3:0]  rsp_entry_slot;
   logic [8:0]  rsp_entry_index;
   logic [63:0] rsp_entry_value;
   logic [1:0]  rsp_tables_added;
   logic        rsp_last_page;
   logic        csr_valid      = 1'b0;
   logic        csr_ready;
   logic        csr_index      = 1'b0;
   logic [47:0] csr_data       = '0;

   mapping_scoreboard_type board;
   bit                     idle_on      = 1'b1;
   int                     quiet_cycles = 0;

   page_table_mapper_unit u_top (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_virt_base    (req_virt_base),
      .req_phys_base    (req_phys_base),
      .req_page_order   (req_page_order),
      .req_page_count   (req_page_count),
      .req_attributes   (req_attributes),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_entry_level  (rsp_entry_level),
      .rsp_entry_slot   (rsp_entry_slot),
      .rsp_entry_index  (rsp_entry_index),
      .rsp_entry_value  (rsp_entry_value),
      .rsp_tables_added (rsp_tables_added),
      .rsp_last_page    (rsp_last_page),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always #5 clock = ~clock;

   // monitor: results first, then request and register beats of this edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid === 1'b1)
            board.check_entry(entry_beat_type'{rsp_status, rsp_entry_level,
                                               rsp_entry_slot, rsp_entry_index,
                                               rsp_entry_value, rsp_tables_added,
                                               rsp_last_page});
         if (start && busy === 1'b0)
            board.note_request(req_virt_base, req_phys_base, req_page_order,
                               req_page_count, req_attributes);
         if (csr_valid && csr_ready === 1'b1)
            board.set_register(csr_index, csr_data);
      end
   end

   // watchdog on cycles without any beat
   always @(posedge clock) begin
      if ((start && busy === 1'b0) || rsp_valid === 1'b1 || (csr_valid && csr_ready === 1'b1))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   function automatic logic [47:0] rand48();
      return {16'($urandom), $urandom};
   endfunction

   // one request beat, then maybe a random gap
   task automatic send_request(input logic [47:0] virt, input logic [47:0] phys,
                               input logic [5:0] order, input logic [6:0] count,
                               input logic [63:0] attr);
      start          <= 1'b1;
      req_virt_base  <= virt;
      req_phys_base  <= phys;
      req_page_order <= order;
      req_page_count <= count;
      req_attributes <= attr;
      do @(posedge clock); while (busy !== 1'b0);
      if (idle_on && $urandom_range(99) < 15) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
   endtask

   // hold off until every predicted beat is in and the block is quiet
   task automatic settle();
      start <= 1'b0;
      do @(posedge clock); while (board.pending() != 0 || busy !== 1'b0);
      repeat (10) @(posedge clock);
   endtask

   // both registers back to back; junk above the depth bits
   task automatic set_mode(input logic [2:0] depth, input logic [47:0] pool);
      csr_valid <= 1'b1;
      csr_index <= ptm_pkg::CSR_ROOT_DEPTH;
      csr_data  <= (rand48() & ~48'h7) | 48'(depth);
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_index <= ptm_pkg::CSR_POOL_BASE;
      csr_data  <= pool;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
   endtask

   // mostly well-formed runs into the shared regions, some raw noise
   task automatic run_random(input int unsigned items, input int unsigned noise_pct);
      logic [47:0] virt, region;
      logic [5:0]  order;
      logic [6:0]  count;
      logic [63:0] attr;
      int unsigned pick;
      for (int n = 0; n < items; n++) begin
         region = $urandom_range(1) ? REGION_HI : REGION_LO;
         attr   = ($urandom_range(3) == 0) ? 64'd0 : {$urandom, $urandom};
         pick   = $urandom_range(99);
         if (pick < 3)
            count = 7'd0;
         else if (pick < 6)
            count = 7'($urandom_range(65, 127));
         else if (pick < 16)
            count = 7'($urandom_range(9, 64));
         else
            count = 7'($urandom_range(1, 8));
         if ($urandom_range(99) < noise_pct) begin
            virt  = rand48();
            order = 6'($urandom_range(63));
            count = 7'($urandom_range(127));
         end else begin
            case ($urandom_range(9))
               0, 1, 2, 3, 4, 5: begin
                  // 4 KiB pages in the first two 2 MiB windows
                  order = 6'd12;
                  virt  = region + 48'($urandom_range(32'h003C_0FFF));
               end
               6, 7: begin
                  // 2 MiB blocks from level-2 entry 8 up
                  order = 6'd21;
                  virt  = region + 48'h100_0000 + 48'($urandom_range(32'h007F_FFFF));
               end
               8: begin
                  // 1 GiB blocks from level-1 entry 2 up
                  order = 6'd30;
                  virt  = region + (48'($urandom_range(2, 5)) << 30)
                          + 48'($urandom_range(32'h3FFF_FFFF));
               end
               default: begin
                  // 512 GiB blocks at root entries 100 and up
                  order = 6'd39;
                  virt  = (48'($urandom_range(100, 103)) << 39)
                          | (rand48() & 48'h7F_FFFF_FFFF);
               end
            endcase
         end
         send_request(virt, rand48(), order, count, attr);
      end
   endtask

   // -------------------------------------------------------------------------
   // Test sequence
   // -------------------------------------------------------------------------
   initial begin
      board = new;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      // table RAM clear keeps busy high after reset
      settle();

      // full four-level walks
      set_mode(3'd4, POOL_A);
      send_request(48'h0, 48'h0, 6'd12, 7'd1, 64'd0);
      send_request(48'h0000_0000_1fff, 48'hffff_ffff_ffff, 6'd12, 7'd3, '1);
      // top of the address space, second page wraps back to root entry zero
      send_request(48'hffff_ffff_ffff, 48'h0, 6'd12, 7'd2, 64'd0);
      send_request(REGION_HI, 48'h1234_5678_9000, 6'd12, 7'd64,
                   64'h0060_0000_0000_0703);
      send_request(48'h0000_0100_0000, 48'h0000_4020_0000, 6'd21, 7'd2, 64'd1);
      send_request(48'h0000_8000_0000, 48'h0080_0000_0000, 6'd30, 7'd1, 64'h401);
      send_request(48'h3200_0000_0000, 48'h0, 6'd39, 7'd2, 64'h8000_0000_0000_0001);
      // orders that match no level
      send_request(48'h0000_0000_5000, rand48(), 6'd0, 7'd1, 64'd0);
      send_request(48'h0000_0000_5000, rand48(), 6'd63, 7'd9, '1);
      send_request(48'h0000_0000_5000, rand48(), 6'd13, 7'd5, 64'd0);
      send_request(48'h0000_0000_5000, rand48(), 6'd38, 7'd1, 64'd0);
      // empty run, then a saturated one
      send_request(48'h0000_0000_1000, rand48(), 6'd12, 7'd0, 64'd0);
      send_request(48'h0000_0000_1000, rand48(), 6'd12, 7'd127, 64'h3);
      // block leaf that happens to point into the pool, then walked through
      send_request(48'h0000_0200_0000, POOL_A + 48'h2000, 6'd21, 7'd1, 64'd3);
      send_request(48'h0000_0212_C000, rand48(), 6'd12, 7'd2, 64'd0);
      // block leaf pointing below the pool: walk through it fails
      send_request(48'h0000_0220_0000, 48'h0000_0000_0800, 6'd21, 7'd1, 64'd0);
      send_request(48'h0000_0220_3000, rand48(), 6'd12, 7'd3, 64'd0);
      // run crossing into a new 2 MiB window
      send_request(48'h0080_001F_F000, rand48(), 6'd12, 7'd4, 64'h7);

      idle_on = 1'b0;
      run_random(15, 10);
      idle_on = 1'b1;
      settle();
      run_random(15, 10);

      // walk from level two
      settle();
      set_mode(3'd2, POOL_A);
      run_random(20, 10);

      // depth beyond four acts as four; fresh root entries drain the pool
      settle();
      set_mode(3'd7, POOL_A);
      send_request(48'h6400_0000_0000, rand48(), 6'd12, 7'd1, 64'd0);
      send_request(48'h6480_0000_0000, rand48(), 6'd12, 7'd2, 64'd0);
      send_request(48'h6500_0000_0000, rand48(), 6'd12, 7'd1, 64'd0);
      run_random(15, 40);

      // root-only walk, pool at zero
      settle();
      set_mode(3'd1, 48'h0);
      run_random(20, 10);

      // pool moved to the top: old pointers fall outside, base unaligned
      settle();
      set_mode(3'd3, 48'hffff_ffff_ffff);
      run_random(10, 20);

      // no levels at all
      settle();
      set_mode(3'd0, POOL_A);
      send_request(48'h0, rand48(), 6'd12, 7'd1, 64'd0);
      send_request(48'h0, rand48(), 6'd39, 7'd64, '1);
      run_random(5, 20);

      settle();
      if (board.close_out() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
